### rtl/swlru_pkg.sv
// ----------------------------------------------------------------------------
// Size-weighted LRU store package
// Shared constants, opcodes, status codes and controller/datapath structs.
// ----------------------------------------------------------------------------
package swlru_pkg;

	localparam int ENTRIES    = 16;
	localparam int IDX_W      = $clog2(ENTRIES);
	localparam int CNT_W      = $clog2(ENTRIES + 1);
	localparam int SIZE_LIMIT = 1024 * 1024;
	localparam int SIZE_W     = 21;
	localparam int TOTAL_W    = 22;
	localparam int KEY_W      = 32;
	localparam int HANDLE_W   = 32;

	typedef enum logic [1:0] {
		OP_GET   = 2'd0,
		OP_PUT   = 2'd1,
		OP_CLEAR = 2'd2,
		OP_NONE  = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		ST_DONE    = 2'd0,
		ST_MISS    = 2'd1,
		ST_REJECT  = 2'd2,
		ST_CLEARED = 2'd3
	} status_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;      // capture the input item
		logic touch;     // make the matched slot most recent (get hit)
		logic update;    // overwrite the matched slot (put hit)
		logic insert;    // insert into the lowest free slot (put miss)
		logic evict;     // evict the least-recent valid entry
		logic clear;     // invalidate all entries
	} swlru_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic    hit;        // captured key matches a valid entry
		logic    full;       // every slot is valid
		logic    over;       // byte total exceeds the capacity
		logic    empty;      // no valid entry
		logic    bad_size;   // captured put size is out of range
		opcode_t op;         // captured opcode
	} swlru_sts_t;

endpackage

### rtl/size_weighted_lru_store.sv
// ----------------------------------------------------------------------------
// Size-weighted LRU store
// Least-recently-used table of 16 entries limited by a total byte budget.
// ----------------------------------------------------------------------------
//
//   channel  | valid      | stall      | payload
//   ---------+------------+------------+--------------------------------------
//   input    | in_valid   | in_stall   | opcode, key_tag, value_handle, value_bytes
//   output   | out_valid  | out_stall  | status, read_handle, used_bytes, live_entries
//   config   | cfg_we     | -          | cfg_data (capacity_bytes)
//
// A get, a clear, an unused opcode or a rejected put goes from the execute
// state to the done state; a put to a present key passes through the trim
// state and a put of a new key through make-room, insert and trim. The trim
// loop evicts one least-recent entry per cycle through the shared table until
// the total fits the budget. In the done state the result is loaded once the
// output register is free, and the next item can be taken in the cycle after.
// One item is in work at a time; in_stall is high until the result has moved
// into the output register. The output register holds while out_stall is high.
// Reset clears all entries, the byte total and sets capacity to 1048576.
module size_weighted_lru_store (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [swlru_pkg::SIZE_W-1:0]         cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [1:0]                           opcode,
	input  logic [swlru_pkg::KEY_W-1:0]          key_tag,
	input  logic [swlru_pkg::HANDLE_W-1:0]       value_handle,
	input  logic [swlru_pkg::SIZE_W-1:0]         value_bytes,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [1:0]                           status,
	output logic [swlru_pkg::HANDLE_W-1:0]       read_handle,
	output logic [swlru_pkg::TOTAL_W-1:0]        used_bytes,
	output logic [swlru_pkg::CNT_W-1:0]          live_entries
);

	swlru_pkg::swlru_cmd_t              cmd;
	swlru_pkg::swlru_sts_t              sts;
	logic                               res_load;
	swlru_pkg::status_t                 res_status;
	logic                               res_hit;
	logic [swlru_pkg::HANDLE_W-1:0]     hit_handle;
	logic [swlru_pkg::TOTAL_W-1:0]      total_bytes;
	logic [swlru_pkg::CNT_W-1:0]        live_count;

	swlru_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.cmd        (cmd),
		.sts        (sts),
		.res_load   (res_load),
		.res_status (res_status),
		.res_hit    (res_hit)
	);

	swlru_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.cfg_we      (cfg_we),
		.cfg_data    (cfg_data),
		.in_opcode   (opcode),
		.in_key      (key_tag),
		.in_handle   (value_handle),
		.in_bytes    (value_bytes),
		.hit_handle  (hit_handle),
		.total_bytes (total_bytes),
		.live_count  (live_count)
	);

	// Output register: the payload is captured when the result is finished
	// and the register is free, then holds until the item is taken.
	always_ff @(posedge clk) begin
		if (res_load) begin
			status       <= res_status;
			read_handle  <= res_hit ? hit_handle : '0;
			used_bytes   <= total_bytes;
			live_entries <= live_count;
		end
	end

endmodule

### rtl/swlru_datapath.sv
// ----------------------------------------------------------------------------
// Size-weighted LRU datapath
// Entry table, recency ranks, byte total and capacity register.
// ----------------------------------------------------------------------------
module swlru_datapath (
	input  logic                             clk,
	input  logic                             arst_n,
	input  swlru_pkg::swlru_cmd_t            cmd,
	output swlru_pkg::swlru_sts_t            sts,
	input  logic                             cfg_we,
	input  logic [swlru_pkg::SIZE_W-1:0]     cfg_data,
	input  logic [1:0]                       in_opcode,
	input  logic [swlru_pkg::KEY_W-1:0]      in_key,
	input  logic [swlru_pkg::HANDLE_W-1:0]   in_handle,
	input  logic [swlru_pkg::SIZE_W-1:0]     in_bytes,
	output logic [swlru_pkg::HANDLE_W-1:0]   hit_handle,
	output logic [swlru_pkg::TOTAL_W-1:0]    total_bytes,
	output logic [swlru_pkg::CNT_W-1:0]      live_count
);

	logic [swlru_pkg::ENTRIES-1:0]    valid_q;
	logic [swlru_pkg::KEY_W-1:0]      key_q    [swlru_pkg::ENTRIES];
	logic [swlru_pkg::HANDLE_W-1:0]   handle_q [swlru_pkg::ENTRIES];
	logic [swlru_pkg::SIZE_W-1:0]     size_q   [swlru_pkg::ENTRIES];
	logic [swlru_pkg::IDX_W-1:0]      rank_q   [swlru_pkg::ENTRIES];
	logic [swlru_pkg::TOTAL_W-1:0]    total_q;
	logic [swlru_pkg::SIZE_W-1:0]     cap_q;

	logic [1:0]                       op_q;
	logic [swlru_pkg::KEY_W-1:0]      key_in_q;
	logic [swlru_pkg::HANDLE_W-1:0]   handle_in_q;
	logic [swlru_pkg::SIZE_W-1:0]     bytes_in_q;

	logic [swlru_pkg::ENTRIES-1:0]    match;
	logic [swlru_pkg::IDX_W-1:0]      hit_idx;
	logic [swlru_pkg::IDX_W-1:0]      free_idx;
	logic [swlru_pkg::IDX_W-1:0]      old_idx;
	logic [swlru_pkg::CNT_W-1:0]      cnt;

	always_comb begin
		hit_idx  = '0;
		free_idx = '0;
		old_idx  = '0;
		cnt      = '0;
		for (int i = swlru_pkg::ENTRIES - 1; i >= 0; i--) begin
			match[i] = valid_q[i] && (key_q[i] == key_in_q);
			if (match[i]) hit_idx = swlru_pkg::IDX_W'(i);
			if (!valid_q[i]) free_idx = swlru_pkg::IDX_W'(i);
			cnt = cnt + swlru_pkg::CNT_W'(valid_q[i]);
		end
		for (int i = 0; i < swlru_pkg::ENTRIES; i++) begin
			// valid ranks are 0..live-1; the oldest holds live-1
			if (valid_q[i] && (swlru_pkg::CNT_W'(rank_q[i]) == cnt - 1'b1))
				old_idx = swlru_pkg::IDX_W'(i);
		end
	end

	assign live_count  = cnt;
	assign total_bytes = total_q;
	assign hit_handle  = handle_q[hit_idx];

	assign sts.hit      = |match;
	assign sts.full     = &valid_q;
	assign sts.over     = total_q > swlru_pkg::TOTAL_W'(cap_q);
	assign sts.empty    = ~|valid_q;
	assign sts.bad_size = (bytes_in_q == '0) ||
		(bytes_in_q > swlru_pkg::SIZE_W'(swlru_pkg::SIZE_LIMIT));
	assign sts.op       = swlru_pkg::opcode_t'(op_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= swlru_pkg::SIZE_W'(swlru_pkg::SIZE_LIMIT);
		end else if (cfg_we) begin
			cap_q <= (cfg_data > swlru_pkg::SIZE_W'(swlru_pkg::SIZE_LIMIT)) ?
				swlru_pkg::SIZE_W'(swlru_pkg::SIZE_LIMIT) : cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q        <= in_opcode;
			key_in_q    <= in_key;
			handle_in_q <= in_handle;
			bytes_in_q  <= in_bytes;
		end
		if (cmd.update) begin
			handle_q[hit_idx] <= handle_in_q;
			size_q[hit_idx]   <= bytes_in_q;
		end
		if (cmd.insert) begin
			key_q[free_idx]    <= key_in_q;
			handle_q[free_idx] <= handle_in_q;
			size_q[free_idx]   <= bytes_in_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			total_q <= '0;
			for (int i = 0; i < swlru_pkg::ENTRIES; i++) rank_q[i] <= '0;
		end else begin
			if (cmd.clear) begin
				valid_q <= '0;
				total_q <= '0;
				for (int i = 0; i < swlru_pkg::ENTRIES; i++) rank_q[i] <= '0;
			end else if (cmd.touch || cmd.update) begin
				for (int i = 0; i < swlru_pkg::ENTRIES; i++)
					if (valid_q[i] && !match[i] && rank_q[i] < rank_q[hit_idx])
						rank_q[i] <= rank_q[i] + 1'b1;
				rank_q[hit_idx] <= '0;
				if (cmd.update)
					total_q <= total_q - swlru_pkg::TOTAL_W'(size_q[hit_idx])
						+ swlru_pkg::TOTAL_W'(bytes_in_q);
			end else if (cmd.insert) begin
				for (int i = 0; i < swlru_pkg::ENTRIES; i++)
					if (valid_q[i]) rank_q[i] <= rank_q[i] + 1'b1;
				rank_q[free_idx]  <= '0;
				valid_q[free_idx] <= 1'b1;
				total_q <= total_q + swlru_pkg::TOTAL_W'(bytes_in_q);
			end else if (cmd.evict) begin
				valid_q[old_idx] <= 1'b0;
				total_q <= total_q - swlru_pkg::TOTAL_W'(size_q[old_idx]);
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(match)) else $error("key held by two slots");
	assert property (@(posedge clk) disable iff (!arst_n)
		sts.empty |-> total_q == '0) else $error("bytes held by empty store");
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.insert |-> !sts.full) else $error("insert into full table");

endmodule

### rtl/swlru_ctrl.sv
// ----------------------------------------------------------------------------
// Size-weighted LRU controller
// Sequences lookup, update or insert, eviction and the result handshake.
// ----------------------------------------------------------------------------
module swlru_ctrl (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	output logic                    out_valid,
	input  logic                    out_stall,
	output swlru_pkg::swlru_cmd_t   cmd,
	input  swlru_pkg::swlru_sts_t   sts,
	output logic                    res_load,
	output swlru_pkg::status_t      res_status,
	output logic                    res_hit
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_MAKE_ROOM,
		S_INSERT,
		S_TRIM,
		S_DONE
	} state_t;

	state_t state_q;
	logic   out_free;

	assign out_free = !out_valid || !out_stall;
	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		cmd        = '0;
		res_load   = 1'b0;
		res_status = swlru_pkg::ST_DONE;
		res_hit    = 1'b0;
		cmd.load   = (state_q == S_IDLE) && in_valid;
		unique case (state_q)
			S_EXEC: begin
				unique case (sts.op)
					swlru_pkg::OP_GET:   cmd.touch  = sts.hit;
					swlru_pkg::OP_PUT:   cmd.update = !sts.bad_size && sts.hit;
					swlru_pkg::OP_CLEAR: cmd.clear  = 1'b1;
					default: ;
				endcase
			end
			S_MAKE_ROOM: cmd.evict  = sts.full;
			S_INSERT:    cmd.insert = 1'b1;
			S_TRIM:      cmd.evict  = sts.over && !sts.empty;
			S_DONE: begin
				res_load = out_free;
				unique case (sts.op)
					swlru_pkg::OP_GET: begin
						res_status = sts.hit ? swlru_pkg::ST_DONE : swlru_pkg::ST_MISS;
						res_hit    = sts.hit;
					end
					swlru_pkg::OP_PUT:
						res_status = sts.bad_size ? swlru_pkg::ST_REJECT : swlru_pkg::ST_DONE;
					swlru_pkg::OP_CLEAR: res_status = swlru_pkg::ST_CLEARED;
					default: res_status = swlru_pkg::ST_DONE;
				endcase
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			out_valid <= 1'b0;
		end else begin
			out_valid <= res_load || (out_valid && out_stall);
			unique case (state_q)
				S_IDLE: if (in_valid) state_q <= S_EXEC;
				S_EXEC: begin
					if (sts.op == swlru_pkg::OP_PUT && !sts.bad_size)
						state_q <= sts.hit ? S_TRIM : S_MAKE_ROOM;
					else
						state_q <= S_DONE;
				end
				S_MAKE_ROOM: state_q <= S_INSERT;
				S_INSERT:    state_q <= S_TRIM;
				S_TRIM:      if (!(sts.over && !sts.empty)) state_q <= S_DONE;
				S_DONE:      if (out_free) state_q <= S_IDLE;
				default:     state_q <= S_IDLE;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && !out_free) |=> state_q == S_DONE)
		else $error("result dropped while output full");
	assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.touch, cmd.update, cmd.insert, cmd.evict, cmd.clear}))
		else $error("conflicting datapath commands");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_INSERT) |-> $past(state_q) == S_MAKE_ROOM)
		else $error("insert without room check");

endmodule

### tb/tb_size_weighted_lru_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the size-weighted LRU store
// Drives get, put and clear items through the valid/stall input channel and
// checks every result against a behavioral copy of the store kept in the
// testbench, across several byte budgets and idle patterns on both sides.
// ----------------------------------------------------------------------------
module tb_size_weighted_lru_store;

	// A 20 ns clock period.
	logic clk;
	logic arst_n;

	// Configuration port.
	logic                                cfg_we;
	logic [swlru_pkg::SIZE_W-1:0]        cfg_data;

	// Input channel.
	logic                                in_valid;
	logic                                in_stall;
	logic [1:0]                          opcode;
	logic [swlru_pkg::KEY_W-1:0]         key_tag;
	logic [swlru_pkg::HANDLE_W-1:0]      value_handle;
	logic [swlru_pkg::SIZE_W-1:0]        value_bytes;

	// Output channel.
	logic                                out_valid;
	logic                                out_stall;
	logic [1:0]                          status;
	logic [swlru_pkg::HANDLE_W-1:0]      read_handle;
	logic [swlru_pkg::TOTAL_W-1:0]       used_bytes;
	logic [swlru_pkg::CNT_W-1:0]         live_entries;

	// One result as the store should report it.
	typedef struct packed {
		logic [1:0]                     st;
		logic [swlru_pkg::HANDLE_W-1:0] handle;
		logic [swlru_pkg::TOTAL_W-1:0]  used;
		logic [swlru_pkg::CNT_W-1:0]    live;
	} lookup_result_t;

	lookup_result_t pending_results[$];

	// Shadow copy of the store's table.
	logic                                shadow_valid [swlru_pkg::ENTRIES];
	logic [swlru_pkg::KEY_W-1:0]         shadow_key   [swlru_pkg::ENTRIES];
	logic [swlru_pkg::HANDLE_W-1:0]      shadow_handle[swlru_pkg::ENTRIES];
	int unsigned                         shadow_size  [swlru_pkg::ENTRIES];
	int unsigned                         shadow_rank  [swlru_pkg::ENTRIES];
	int unsigned                         shadow_total;
	int unsigned                         shadow_capacity;

	// Idle pacing, in percent, for each side; the long hold-off overrides.
	int  send_idle_pct;
	int  stall_pct;
	bit  hold_off;
	int  hold_cycles;

	int  errors;
	int  results_seen;
	int  items_sent;
	longint cycle_count;

	// Keys of the first 40 puts, so random gets and puts hit often.
	logic [swlru_pkg::KEY_W-1:0] key_pool[$];

	size_weighted_lru_store uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.opcode       (opcode),
		.key_tag      (key_tag),
		.value_handle (value_handle),
		.value_bytes  (value_bytes),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.read_handle  (read_handle),
		.used_bytes   (used_bytes),
		.live_entries (live_entries)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Generous limit for about 1000 items, even with heavy stalling and a full
	// eviction run per put.
	initial begin
		cycle_count = 0;
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count > 600000) begin
				$display("Timeout after %0d cycles", cycle_count);
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// Behavioral model of the store
	// ------------------------------------------------------------------

	function automatic int count_live();
		int n;
		n = 0;
		for (int i = 0; i < swlru_pkg::ENTRIES; i++)
			if (shadow_valid[i])
				n++;
		return n;
	endfunction

	// Drop the valid entry with the largest rank, the least recently used.
	function automatic void drop_oldest();
		int victim;
		victim = -1;
		for (int i = 0; i < swlru_pkg::ENTRIES; i++)
			if (shadow_valid[i] && (victim < 0 || shadow_rank[i] > shadow_rank[victim]))
				victim = i;
		if (victim >= 0) begin
			shadow_valid[victim] = 1'b0;
			shadow_total -= shadow_size[victim];
		end
	endfunction

	function automatic void promote(int s);
		int unsigned r;
		r = shadow_rank[s];
		for (int i = 0; i < swlru_pkg::ENTRIES; i++)
			if (shadow_valid[i] && i != s && shadow_rank[i] < r)
				shadow_rank[i]++;
		shadow_rank[s] = 0;
	endfunction

	function automatic int lookup_slot(logic [swlru_pkg::KEY_W-1:0] k);
		for (int i = 0; i < swlru_pkg::ENTRIES; i++)
			if (shadow_valid[i] && shadow_key[i] == k)
				return i;
		return -1;
	endfunction

	function automatic void reset_shadow();
		for (int i = 0; i < swlru_pkg::ENTRIES; i++) begin
			shadow_valid[i] = 1'b0;
			shadow_rank[i]  = 0;
		end
		shadow_total    = 0;
		shadow_capacity = 32'(swlru_pkg::SIZE_LIMIT);
	endfunction

	// Apply one item to the shadow store and return what the block should say.
	function automatic lookup_result_t apply_item(logic [1:0] op,
			logic [swlru_pkg::KEY_W-1:0] k, logic [swlru_pkg::HANDLE_W-1:0] h,
			logic [swlru_pkg::SIZE_W-1:0] b);
		lookup_result_t r;
		int s;
		r = '0;
		r.st = swlru_pkg::ST_DONE;
		case (swlru_pkg::opcode_t'(op))
			swlru_pkg::OP_GET: begin
				s = lookup_slot(k);
				if (s < 0) begin
					r.st = swlru_pkg::ST_MISS;
				end else begin
					r.handle = shadow_handle[s];
					promote(s);
				end
			end
			swlru_pkg::OP_PUT: begin
				if (b == '0 || b > swlru_pkg::SIZE_W'(swlru_pkg::SIZE_LIMIT)) begin
					r.st = swlru_pkg::ST_REJECT;
				end else begin
					s = lookup_slot(k);
					if (s >= 0) begin
						shadow_total = shadow_total - shadow_size[s] + 32'(b);
						shadow_size[s]   = 32'(b);
						shadow_handle[s] = h;
						promote(s);
					end else begin
						// A full table gives up its oldest entry first.
						if (count_live() >= swlru_pkg::ENTRIES)
							drop_oldest();
						for (int i = swlru_pkg::ENTRIES - 1; i >= 0; i--)
							if (!shadow_valid[i])
								s = i;
						for (int i = 0; i < swlru_pkg::ENTRIES; i++)
							if (shadow_valid[i])
								shadow_rank[i]++;
						shadow_valid[s]  = 1'b1;
						shadow_key[s]    = k;
						shadow_handle[s] = h;
						shadow_size[s]   = 32'(b);
						shadow_rank[s]   = 0;
						shadow_total    += 32'(b);
					end
					// Trim to the budget; this may remove the entry just put.
					while (shadow_total > shadow_capacity && count_live() > 0)
						drop_oldest();
				end
			end
			swlru_pkg::OP_CLEAR: begin
				for (int i = 0; i < swlru_pkg::ENTRIES; i++) begin
					shadow_valid[i] = 1'b0;
					shadow_rank[i]  = 0;
				end
				shadow_total = 0;
				r.st = swlru_pkg::ST_CLEARED;
			end
			default: ;
		endcase
		r.used = swlru_pkg::TOTAL_W'(shadow_total);
		r.live = swlru_pkg::CNT_W'(count_live());
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Channel drivers and the result checker
	// ------------------------------------------------------------------

	// Present one item, with a random idle gap first, and wait until taken.
	// The task returns at the falling edge after acceptance; the next item,
	// an idle gap or a drain then takes over the input at that same edge.
	task automatic send_item(logic [1:0] op, logic [swlru_pkg::KEY_W-1:0] k,
			logic [swlru_pkg::HANDLE_W-1:0] h, logic [swlru_pkg::SIZE_W-1:0] b);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid     <= 1'b1;
		opcode       <= op;
		key_tag      <= k;
		value_handle <= h;
		value_bytes  <= b;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		// Predict at acceptance; items are handled strictly in order.
		pending_results.push_back(apply_item(op, k, h, b));
		items_sent++;
		if (op == swlru_pkg::OP_PUT && key_pool.size() < 40)
			key_pool.push_back(k);
		@(negedge clk);
	endtask

	// The receiver stalls at random, or for a long counted stretch on request.
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off && hold_cycles > 0) begin
				out_stall <= 1'b1;
				hold_cycles--;
			end else begin
				out_stall <= ($urandom_range(99) < stall_pct);
			end
		end
	end

	// Every accepted result is compared with the oldest expectation.
	initial begin
		lookup_result_t want;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall) begin
				results_seen++;
				if (pending_results.size() == 0) begin
					$display("%0t: result with nothing expected: status %0d", $time, status);
					errors++;
				end else begin
					want = pending_results.pop_front();
					if (status !== want.st) begin
						$display("%0t: status expected %0d actual %0d", $time, want.st, status);
						errors++;
					end
					if (read_handle !== want.handle) begin
						$display("%0t: read_handle expected %h actual %h",
							$time, want.handle, read_handle);
						errors++;
					end
					if (used_bytes !== want.used) begin
						$display("%0t: used_bytes expected %0d actual %0d",
							$time, want.used, used_bytes);
						errors++;
					end
					if (live_entries !== want.live) begin
						$display("%0t: live_entries expected %0d actual %0d",
							$time, want.live, live_entries);
						errors++;
					end
				end
			end
		end
	end

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// Write the byte budget; only called with nothing in flight.
	task automatic set_capacity(logic [swlru_pkg::SIZE_W-1:0] value);
		wait_drained();
		repeat (30) @(negedge clk);
		cfg_we   <= 1'b1;
		cfg_data <= value;
		@(negedge clk);
		cfg_we   <= 1'b0;
		shadow_capacity = (value > swlru_pkg::SIZE_W'(swlru_pkg::SIZE_LIMIT)) ?
			32'(swlru_pkg::SIZE_LIMIT) : 32'(value);
	endtask

	function automatic logic [swlru_pkg::KEY_W-1:0] pick_key();
		if (key_pool.size() != 0 && $urandom_range(99) < 75)
			return key_pool[$urandom_range(key_pool.size() - 1)];
		return $urandom();
	endfunction

	// Mostly in-range sizes, scaled so that the budget is exercised.
	function automatic logic [swlru_pkg::SIZE_W-1:0] pick_size();
		int unsigned sel;
		sel = $urandom_range(99);
		if (sel < 4)
			return '0;
		if (sel < 8)
			return swlru_pkg::SIZE_W'($urandom_range(2097151, swlru_pkg::SIZE_LIMIT + 1));
		if (sel < 12)
			return swlru_pkg::SIZE_W'($urandom_range(swlru_pkg::SIZE_LIMIT,
				swlru_pkg::SIZE_LIMIT / 2));
		if (shadow_capacity > 16)
			return swlru_pkg::SIZE_W'($urandom_range(shadow_capacity / 6 + 1, 1));
		return swlru_pkg::SIZE_W'($urandom_range(8, 1));
	endfunction

	task automatic random_items(int n);
		int unsigned sel;
		logic [1:0] op;
		for (int i = 0; i < n; i++) begin
			sel = $urandom_range(99);
			if (sel < 55)
				op = swlru_pkg::OP_PUT;
			else if (sel < 93)
				op = swlru_pkg::OP_GET;
			else if (sel < 97)
				op = swlru_pkg::OP_NONE;
			else
				op = swlru_pkg::OP_CLEAR;
			send_item(op, pick_key(), $urandom(), pick_size());
		end
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Field extremes, every opcode, rejected sizes, full table and clear.
	task automatic test_directed();
		send_item(swlru_pkg::OP_GET,   32'h0, 32'h0, '0);
		send_item(swlru_pkg::OP_PUT,   32'h0, 32'hFFFF_FFFF, 21'd0);
		send_item(swlru_pkg::OP_PUT,   32'h1, 32'h1,
			swlru_pkg::SIZE_W'(swlru_pkg::SIZE_LIMIT + 1));
		send_item(swlru_pkg::OP_PUT,   32'h2, 32'h2, 21'h1F_FFFF);
		send_item(swlru_pkg::OP_PUT,   32'hFFFF_FFFF, 32'hA5A5_5A5A, 21'd1);
		send_item(swlru_pkg::OP_PUT,   32'h0, 32'hFFFF_FFFF,
			swlru_pkg::SIZE_W'(swlru_pkg::SIZE_LIMIT));
		send_item(swlru_pkg::OP_GET,   32'hFFFF_FFFF, 32'h0, '0);
		send_item(swlru_pkg::OP_GET,   32'h0, 32'h0, 21'h1F_FFFF);
		send_item(swlru_pkg::OP_NONE,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 21'h1F_FFFF);
		// Eighteen small puts overflow the table of sixteen entries.
		for (int i = 0; i < 18; i++)
			send_item(swlru_pkg::OP_PUT, 32'(32'h100 + i), 32'(32'hC000_0000 + i), 21'd3);
		send_item(swlru_pkg::OP_PUT,   32'h105, 32'h1234_5678, 21'd100);
		send_item(swlru_pkg::OP_GET,   32'h102, 32'h0, '0);
		send_item(swlru_pkg::OP_CLEAR, 32'h0, 32'h0, '0);
		send_item(swlru_pkg::OP_GET,   32'h105, 32'h0, '0);
	endtask

	// Zero, tiny and saturated budgets; puts may trim themselves or neighbors away.
	task automatic test_small_budget();
		set_capacity(21'd0);
		send_item(swlru_pkg::OP_PUT, 32'h55, 32'h55, 21'd1);
		send_item(swlru_pkg::OP_GET, 32'h55, 32'h0, '0);
		set_capacity(21'd10);
		random_items(60);
		set_capacity(21'h1F_FFFF);  // saturates to the size limit
		random_items(40);
	endtask

	// Random traffic under each idling pattern and a few budgets.
	task automatic test_random_phases();
		set_capacity(21'd5000);
		send_idle_pct = 0;  stall_pct = 0;
		random_items(200);
		send_idle_pct = 78; stall_pct = 0;
		random_items(150);
		set_capacity(swlru_pkg::SIZE_W'(swlru_pkg::SIZE_LIMIT));
		send_idle_pct = 0;  stall_pct = 78;
		random_items(200);
		set_capacity(21'd300000);
		send_idle_pct = 15; stall_pct = 15;
		random_items(200);
	endtask

	// Long receiver hold-off under steady offers, then a full drain and more items.
	task automatic test_backpressure();
		send_idle_pct = 0; stall_pct = 0;
		hold_cycles = 300;
		hold_off = 1'b1;
		random_items(40);
		hold_off = 1'b0;
		wait_drained();
		random_items(80);
	endtask

	initial begin
		errors = 0; results_seen = 0; items_sent = 0;
		send_idle_pct = 0; stall_pct = 0; hold_off = 1'b0; hold_cycles = 0;
		arst_n = 1'b0;
		cfg_we = 1'b0; cfg_data = '0;
		in_valid = 1'b0; opcode = '0; key_tag = '0; value_handle = '0; value_bytes = '0;
		reset_shadow();
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_directed();
		test_small_budget();
		test_random_phases();
		test_backpressure();

		wait_drained();
		repeat (40) @(negedge clk);
		$display("Covered %0d items and %0d results over gets, puts, clears, idle opcodes,",
			items_sent, results_seen);
		$display("budgets from zero to the limit, and random and long stalls on both sides.");
		if (errors == 0 && pending_results.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("%0d mismatches, %0d results missing", errors, pending_results.size());
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

### filelist.f
rtl/swlru_pkg.sv
rtl/swlru_datapath.sv
rtl/swlru_ctrl.sv
rtl/size_weighted_lru_store.sv
tb/tb_size_weighted_lru_store.sv
